@@ hw/rtl/slui_pkg.sv @@
`timescale 1ns / 1ps

package slui_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_RUN    = 2'd2
    } cmd_t;

    localparam logic MODE_UNION     = 1'b0;
    localparam logic MODE_INTERSECT = 1'b1;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic out_free;
    } dp_status_t;

endpackage

@@ hw/rtl/slui_ctrl.sv @@
`timescale 1ns / 1ps

module slui_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             s_tuser,
    input  slui_pkg::dp_status_t   status,
    output slui_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load_a = accept && (s_tuser == slui_pkg::CMD_LOAD_A);
                cmd.load_b = accept && (s_tuser == slui_pkg::CMD_LOAD_B);
                if (accept && (s_tuser == slui_pkg::CMD_RUN)) begin
                    cmd.start  = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (status.out_free) begin
                    if (status.walk_done) begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_step_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> !status.walk_done && status.out_free)
        else $error("walk step issued after walk finished or with output busy");

    a_finish_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> s_tready)
        else $error("input not reopened after run finished");

    a_no_load_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> !cmd.load_a && !cmd.load_b && !cmd.start)
        else $error("input command issued during walk");

endmodule

@@ hw/rtl/slui_datapath.sv @@
`timescale 1ns / 1ps

module slui_datapath #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic [slui_pkg::DATA_W-1:0]   s_tdata,
    input  slui_pkg::ctrl_cmd_t           cmd,
    output slui_pkg::dp_status_t          status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [slui_pkg::DATA_W-1:0]   m_tdata,
    output logic                          m_tlast,
    output logic [1:0]                    m_tuser
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int SLOTS = 2 ** IDX_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    logic [slui_pkg::DATA_W-1:0] a_mem [SLOTS];
    logic [slui_pkg::DATA_W-1:0] b_mem [SLOTS];
    logic [slui_pkg::DATA_W-1:0] a_rd_reg;
    logic [slui_pkg::DATA_W-1:0] b_rd_reg;

    logic [CNT_W-1:0] cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0] cnt_b_reg, cnt_b_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             ovf_reg, ovf_next;
    logic             mode_reg, mode_next;
    logic             pend_v_reg, pend_v_next;
    logic [slui_pkg::DATA_W-1:0] pend_reg, pend_next;
    logic             ovalid_reg, ovalid_next;
    logic [slui_pkg::DATA_W-1:0] odata_reg, odata_next;
    logic             olast_reg, olast_next;
    logic             oempty_reg, oempty_next;
    logic             oovf_reg, oovf_next;

    logic [slui_pkg::DATA_W-1:0] a_val, b_val, cand, emit_val;
    logic a_rem, b_rem, a_lt_b, b_lt_a, take_a, emit, adv_i, adv_j;
    logic out_free;

    // read data is registered from the next pointers, so it matches the current ones
    assign a_val  = a_rd_reg;
    assign b_val  = b_rd_reg;
    assign a_rem  = i_reg < cnt_a_reg;
    assign b_rem  = j_reg < cnt_b_reg;
    assign a_lt_b = $signed(a_val) < $signed(b_val);
    assign b_lt_a = $signed(b_val) < $signed(a_val);
    assign take_a = a_rem && (!b_rem || !b_lt_a);
    assign cand   = take_a ? a_val : b_val;

    always_comb begin
        if (mode_reg == slui_pkg::MODE_INTERSECT) begin
            emit     = (a_val == b_val);
            emit_val = a_val;
            adv_i    = !b_lt_a;
            adv_j    = !a_lt_b;
        end else begin
            emit     = !pend_v_reg || (pend_reg != cand);
            emit_val = cand;
            adv_i    = take_a;
            adv_j    = !take_a;
        end
    end

    assign out_free         = !ovalid_reg || m_tready;
    assign status.out_free  = out_free;
    assign status.walk_done = (mode_reg == slui_pkg::MODE_INTERSECT) ?
                              (!a_rem || !b_rem) : (!a_rem && !b_rem);

    always_comb begin
        cnt_a_next  = cnt_a_reg;
        cnt_b_next  = cnt_b_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        ovf_next    = ovf_reg;
        mode_next   = cfg_wr_en ? cfg_wr_data : mode_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        oempty_next = oempty_reg;
        oovf_next   = oovf_reg;

        if (cmd.load_a) begin
            if (cnt_a_reg < DEPTH_C) begin
                cnt_a_next = cnt_a_reg + 1'b1;
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.load_b) begin
            if (cnt_b_reg < DEPTH_C) begin
                cnt_b_next = cnt_b_reg + 1'b1;
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.start) begin
            i_next      = '0;
            j_next      = '0;
            pend_v_next = 1'b0;
        end
        if (cmd.step) begin
            i_next = i_reg + CNT_W'(adv_i);
            j_next = j_reg + CNT_W'(adv_j);
            if (emit) begin
                pend_v_next = 1'b1;
                pend_next   = emit_val;
                if (pend_v_reg) begin
                    ovalid_next = 1'b1;
                    odata_next  = pend_reg;
                    olast_next  = 1'b0;
                    oempty_next = 1'b0;
                    oovf_next   = ovf_reg;
                end
            end
        end
        if (cmd.finish) begin
            ovalid_next = 1'b1;
            odata_next  = pend_v_reg ? pend_reg : '0;
            olast_next  = 1'b1;
            oempty_next = !pend_v_reg;
            oovf_next   = ovf_reg;
            cnt_a_next  = '0;
            cnt_b_next  = '0;
            ovf_next    = 1'b0;
            pend_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_a && (cnt_a_reg < DEPTH_C)) begin
            a_mem[cnt_a_reg[IDX_W-1:0]] <= s_tdata;
        end
        if (cmd.load_b && (cnt_b_reg < DEPTH_C)) begin
            b_mem[cnt_b_reg[IDX_W-1:0]] <= s_tdata;
        end
        a_rd_reg <= a_mem[i_next[IDX_W-1:0]];
        b_rd_reg <= b_mem[j_next[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg  <= '0;
            cnt_b_reg  <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            ovf_reg    <= 1'b0;
            mode_reg   <= slui_pkg::MODE_UNION;
            pend_v_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            cnt_a_reg  <= cnt_a_next;
            cnt_b_reg  <= cnt_b_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            ovf_reg    <= ovf_next;
            mode_reg   <= mode_next;
            pend_v_reg <= pend_v_next;
            ovalid_reg <= ovalid_next;
        end
        pend_reg   <= pend_next;
        odata_reg  <= odata_next;
        olast_reg  <= olast_next;
        oempty_reg <= oempty_next;
        oovf_reg   <= oovf_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = {oovf_reg, oempty_reg};

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_a_reg <= DEPTH_C) && (cnt_b_reg <= DEPTH_C))
        else $error("list count beyond capacity");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (cnt_a_reg == '0) && (cnt_b_reg == '0) && !ovf_reg && m_tvalid && m_tlast)
        else $error("run end did not clear state or post last item");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |=> (i_reg <= cnt_a_reg) && (j_reg <= cnt_b_reg))
        else $error("walk pointer ran past list end");

endmodule

@@ hw/rtl/sorted_list_union_intersection_unit.sv @@
`timescale 1ns / 1ps
// Sorted list union / intersection unit.
// Input stream: s_tuser carries the command (load A, load B, run), s_tdata
// the signed element for loads. Loads are accepted one per cycle while idle;
// a load into a full list is dropped and sets the overflow flag.
// A run closes the input (s_tready low) while the walk advances the list
// pointers one step per cycle whenever the output is free; each step is the
// single compare-and-advance step of the walk over the two stores.
// Output stream: m_tdata is the result value, m_tlast marks the last
// transaction of a run, m_tuser = {overflow_seen, empty_result}. An empty
// answer yields one transaction with m_tuser[0] set and m_tdata zero.
// One result is held back to mark the last, so a result reaches the output
// only when the next one is emitted or the run ends. When the receiver
// stalls the walk pauses; input reopens once the last result is in the output
// register. cfg_wr_en / cfg_wr_data set the mode (0 union, 1 intersection)
// and are to be written only while idle; the block itself does not enforce it.
// Reset (aresetn low, synchronous) clears counts, flag, mode and output
// valid; list contents stay undefined until loaded.

module sorted_list_union_intersection_unit #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [slui_pkg::DATA_W-1:0]  s_tdata,   // element_value
    input  logic [1:0]                   s_tuser,   // command
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [slui_pkg::DATA_W-1:0]  m_tdata,   // result_value
    output logic                         m_tlast,
    output logic [1:0]                   m_tuser    // empty_result, overflow_seen
);

    slui_pkg::ctrl_cmd_t  cmd;
    slui_pkg::dp_status_t status;

    slui_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    slui_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

@@ bench/tb_sorted_list_union_intersection_unit.sv @@
`timescale 1ns / 1ps

module tb_sorted_list_union_intersection_unit;

    localparam int          DEPTH       = 32;
    localparam int          ITEM_TARGET = 460;
    localparam int          SETTLE      = 8;
    localparam int          TAIL_CYCLES = 2 * DEPTH + 16;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam logic [1:0]  CMD_IGNORED = 2'd3;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        empty;
        logic        ovf;
    } result_t;

    typedef struct {
        bit          mode_write;
        logic        mode;
        logic [1:0]  cmd;
        logic [31:0] value;
        bit          typed;
        result_t     res;
    } row_t;

    localparam result_t NO_RES    = '0;
    localparam result_t EMPTY_RES = '{value: 32'd0, last: 1'b1, empty: 1'b1, ovf: 1'b0};

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // element_value
    logic [1:0]  s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // result_value
    logic        m_tlast;
    logic [1:0]  m_tuser;   // empty_result, overflow_seen

    // merge model state
    logic [31:0] list_a [DEPTH];
    logic [31:0] list_b [DEPTH];
    int unsigned cnt_a;
    int unsigned cnt_b;
    logic        ovf_flag;
    logic        merge_mode;
    logic [31:0] last_out;
    bit          emitted;
    result_t     merge_out [$];
    result_t     expect_q [$];

    bit          tx_steady;
    bit          rx_steady;
    int          errors = 0;
    int          items_sent;
    int          results_checked = 0;
    int          union_runs;
    int          intersect_runs;
    int          overflow_runs;
    int          empty_runs;
    int unsigned cycle_count = 0;
    result_t     want;

    row_t directed_rows [27] = '{
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_RUN,    32'h0000_0000, 1'b1, EMPTY_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_A, 32'h8000_0000, 1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_A, 32'h7FFF_FFFF, 1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     CMD_IGNORED,          32'hFFFF_FFFF, 1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_B, 32'h8000_0000, 1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_B, 32'hFFFF_FFFF, 1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_B, 32'h7FFF_FFFF, 1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_RUN,    32'hFFFF_FFFF, 1'b0, NO_RES},
        '{1'b1, slui_pkg::MODE_INTERSECT, slui_pkg::CMD_RUN,    32'h0000_0000, 1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_A, 32'd5,         1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_A, 32'd5,         1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_A, 32'd5,         1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_A, 32'd9,         1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_B, 32'd5,         1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_B, 32'd5,         1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_B, 32'd7,         1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_B, 32'd9,         1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_RUN,    32'h0000_0000, 1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_A, 32'd1,         1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_B, 32'd2,         1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_RUN,    32'h0000_0000, 1'b1, EMPTY_RES},
        '{1'b1, slui_pkg::MODE_UNION,     slui_pkg::CMD_RUN,    32'h0000_0000, 1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_A, 32'd4,         1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_A, 32'd2,         1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_B, 32'd4,         1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_LOAD_B, 32'd3,         1'b0, NO_RES},
        '{1'b0, slui_pkg::MODE_UNION,     slui_pkg::CMD_RUN,    32'h0000_0000, 1'b0, NO_RES}
    };

    sorted_list_union_intersection_unit #(
        .LIST_DEPTH (DEPTH)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expect_q.size());
            $display("FAIL sorted_list_union_intersection_unit");
            $finish;
        end
    end

    function automatic void union_push(logic [31:0] v);
        if (!emitted || last_out != v) begin
            merge_out.insert(merge_out.size(),
                             '{value: v, last: 1'b0, empty: 1'b0, ovf: ovf_flag});
            last_out = v;
            emitted  = 1'b1;
        end
    endfunction

    function automatic void apply_command(logic [1:0] cmd, logic [31:0] value);
        int unsigned i;
        int unsigned j;
        logic [31:0] a;
        logic [31:0] b;
        merge_out.delete();
        case (cmd)
            slui_pkg::CMD_LOAD_A: begin
                if (cnt_a < DEPTH) begin
                    list_a[cnt_a] = value;
                    cnt_a++;
                end else begin
                    ovf_flag = 1'b1;
                end
            end
            slui_pkg::CMD_LOAD_B: begin
                if (cnt_b < DEPTH) begin
                    list_b[cnt_b] = value;
                    cnt_b++;
                end else begin
                    ovf_flag = 1'b1;
                end
            end
            slui_pkg::CMD_RUN: begin
                i = 0;
                j = 0;
                emitted = 1'b0;
                if (merge_mode == slui_pkg::MODE_UNION) begin
                    union_runs++;
                    while (i < cnt_a && j < cnt_b) begin
                        a = list_a[i];
                        b = list_b[j];
                        if (!($signed(b) < $signed(a))) begin
                            union_push(a);
                            i++;
                        end else begin
                            union_push(b);
                            j++;
                        end
                    end
                    while (j < cnt_b) begin
                        union_push(list_b[j]);
                        j++;
                    end
                    while (i < cnt_a) begin
                        union_push(list_a[i]);
                        i++;
                    end
                end else begin
                    intersect_runs++;
                    while (i < cnt_a && j < cnt_b) begin
                        a = list_a[i];
                        b = list_b[j];
                        if ($signed(a) < $signed(b)) begin
                            i++;
                        end else if ($signed(b) < $signed(a)) begin
                            j++;
                        end else begin
                            merge_out.insert(merge_out.size(),
                                             '{value: a, last: 1'b0, empty: 1'b0,
                                               ovf: ovf_flag});
                            last_out = a;
                            emitted  = 1'b1;
                            i++;
                            j++;
                        end
                    end
                end
                if (ovf_flag)
                    overflow_runs++;
                if (merge_out.size() == 0) begin
                    merge_out.insert(0, '{value: 32'd0, last: 1'b1, empty: 1'b1,
                                          ovf: ovf_flag});
                    empty_runs++;
                end else begin
                    merge_out[merge_out.size() - 1].last = 1'b1;
                end
                cnt_a    = 0;
                cnt_b    = 0;
                ovf_flag = 1'b0;
                emitted  = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function automatic void fill_list(output int vals[$], input int len, input int style,
                                      input int base);
        for (int n = 0; n < len; n++) begin
            if (style >= 1 && style <= 3)
                vals.insert(vals.size(), int'($urandom()));
            else
                vals.insert(vals.size(), base + int'($urandom_range(0, 15)));
        end
        if (style != 0)
            vals.sort();
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return $urandom_range(0, 8);
        else if (r < 15)
            return $urandom_range(9, DEPTH - 1);
        else if (r < 17)
            return DEPTH;
        return $urandom_range(DEPTH + 1, DEPTH + 4);
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [31:0] value,
                             input bit typed, input result_t typed_res);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        apply_command(cmd, value);
        items_sent++;
        if (typed)
            expect_q.insert(expect_q.size(), typed_res);
        else
            foreach (merge_out[k]) expect_q.insert(expect_q.size(), merge_out[k]);
    endtask

    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        while (expect_q.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_mode(input logic m);
        drain(SETTLE);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        merge_mode = m;
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_checked <= results_checked + 1;
            if (expect_q.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected transaction, expected none, got data %h",
                         $time, m_tdata);
                $display("    last %b user %b", m_tlast, m_tuser);
            end else begin
                want = expect_q.pop_front();
                if (m_tdata !== want.value) begin
                    errors++;
                    $display("%0t ns: result_value expected %h got %h",
                             $time, want.value, m_tdata);
                end
                if (m_tlast !== want.last) begin
                    errors++;
                    $display("%0t ns: last_of_run expected %b got %b", $time, want.last, m_tlast);
                end
                if (m_tuser[0] !== want.empty) begin
                    errors++;
                    $display("%0t ns: empty_result expected %b got %b",
                             $time, want.empty, m_tuser[0]);
                end
                if (m_tuser[1] !== want.ovf) begin
                    errors++;
                    $display("%0t ns: overflow_seen expected %b got %b",
                             $time, want.ovf, m_tuser[1]);
                end
            end
        end
    end

    // result sink with random backpressure
    initial begin
        int stall;
        m_tready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        int a_vals [$];
        int b_vals [$];
        int len_a;
        int len_b;
        int style;
        int base;
        int ia;
        int ib;
        int run_idx;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cnt_a       = 0;
        cnt_b       = 0;
        ovf_flag    = 1'b0;
        merge_mode  = slui_pkg::MODE_UNION;
        last_out    = '0;
        emitted     = 1'b0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        items_sent  = 0;
        union_runs      = 0;
        intersect_runs  = 0;
        overflow_runs   = 0;
        empty_runs      = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].mode_write)
                write_mode(directed_rows[r].mode);
            else
                send_item(directed_rows[r].cmd, directed_rows[r].value,
                          directed_rows[r].typed, directed_rows[r].res);
        end

        run_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            if (run_idx > 0 && $urandom_range(0, 3) == 0)
                write_mode(1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 5) == 0)
                drain(SETTLE);
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 3))
                0:       base = int'(32'h8000_0000);
                1:       base = int'(32'h7FFF_FFF0);
                default: base = int'($urandom());
            endcase
            if (run_idx == 0) begin
                // full B plus overflowing A, random values: longest run
                len_a = DEPTH + 2;
                len_b = DEPTH;
                style = 1;
            end else begin
                len_a = pick_len();
                len_b = pick_len();
                style = $urandom_range(0, 9);
            end
            a_vals.delete();
            b_vals.delete();
            fill_list(a_vals, len_a, style, base);
            fill_list(b_vals, len_b, style, base);
            ia = 0;
            ib = 0;
            while (ia < a_vals.size() || ib < b_vals.size()) begin
                if ($urandom_range(0, 15) == 0) begin
                    send_item(CMD_IGNORED, $urandom(), 1'b0, NO_RES);
                end else if (ib >= b_vals.size() ||
                             (ia < a_vals.size() && $urandom_range(0, 1) == 1)) begin
                    send_item(slui_pkg::CMD_LOAD_A, a_vals[ia], 1'b0, NO_RES);
                    ia++;
                end else begin
                    send_item(slui_pkg::CMD_LOAD_B, b_vals[ib], 1'b0, NO_RES);
                    ib++;
                end
            end
            send_item(slui_pkg::CMD_RUN, $urandom(), 1'b0, NO_RES);
            run_idx++;
        end

        tx_steady = 1'b0;
        drain(TAIL_CYCLES);

        $display("Ran %0d merges (%0d union, %0d intersection) from %0d input transactions.",
                 union_runs + intersect_runs, union_runs, intersect_runs, items_sent);
        $display("Checked %0d result transactions; %0d runs saw dropped loads, %0d were empty.",
                 results_checked, overflow_runs, empty_runs);
        if (errors == 0 && expect_q.size() == 0) begin
            $display("PASS sorted_list_union_intersection_unit");
        end else begin
            $display("FAIL sorted_list_union_intersection_unit");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/slui_pkg.sv
hw/rtl/slui_ctrl.sv
hw/rtl/slui_datapath.sv
hw/rtl/sorted_list_union_intersection_unit.sv
bench/tb_sorted_list_union_intersection_unit.sv
